// ===== rtl/core/ctan_pkg.sv =====
// ctan_pkg: widths, pipeline payload types and the arctangent table
// for the CORDIC tangent datapath. No dependencies.

package ctan_pkg;

  localparam int unsigned ITERATIONS = 15;
  localparam int unsigned STEP_W     = $clog2(ITERATIONS);

  localparam int unsigned ANGLE_W    = 16;
  localparam int unsigned XY_W       = 19;  // |x|,|y| stay below 2^17
  localparam int unsigned MAG_W      = XY_W - 1;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned DQ_W       = MAG_W + FRAC_W;
  localparam int unsigned DIV_STEPS  = DQ_W;
  localparam int unsigned TAN_W      = 32;

  localparam logic signed [XY_W-1:0] X_START   = XY_W'(65535);
  localparam logic        [TAN_W-1:0] TAN_MAX  = {1'b0, {(TAN_W-1){1'b1}}};
  localparam logic        [TAN_W-1:0] TAN_MIN  = {1'b1, {(TAN_W-1){1'b0}}};

  typedef struct packed {
    logic                       valid;
    logic signed [ANGLE_W-1:0]  target;
    logic signed [XY_W-1:0]     x;
    logic signed [XY_W-1:0]     y;
    logic signed [ANGLE_W-1:0]  sum;
  } ctan_rot_t;

  typedef struct packed {
    logic              valid;
    logic [MAG_W-1:0]  rem;
    logic [DQ_W-1:0]   dq;     // dividend shifting out, quotient shifting in
    logic [MAG_W-1:0]  den;
    logic              neg;    // quotient sign
    logic              xzero;
    logic              yneg;
  } ctan_div_t;

  typedef struct packed {
    logic [TAN_W-1:0]  tangent;
    logic              overflow;
  } ctan_res_t;

  // Arctangent of 2^-i in units of 1/256 degree.
  function automatic logic signed [ANGLE_W-1:0] ctan_atan(input logic [STEP_W-1:0] idx);
    logic signed [ANGLE_W-1:0] v;
    case (idx)
      4'd0:    v = 16'sd11520;
      4'd1:    v = 16'sd6801;
      4'd2:    v = 16'sd3593;
      4'd3:    v = 16'sd1824;
      4'd4:    v = 16'sd916;
      4'd5:    v = 16'sd458;
      4'd6:    v = 16'sd229;
      4'd7:    v = 16'sd115;
      4'd8:    v = 16'sd57;
      4'd9:    v = 16'sd29;
      4'd10:   v = 16'sd14;
      4'd11:   v = 16'sd7;
      4'd12:   v = 16'sd4;
      4'd13:   v = 16'sd2;
      4'd14:   v = 16'sd1;
      default: v = 16'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/ctan_rot_cell.sv =====
// ctan_rot_cell: one rotation-mode CORDIC step, registered.
// Depends on ctan_pkg.

module ctan_rot_cell
  import ctan_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [STEP_W-1:0] step_i,
  input  ctan_rot_t         cell_i,
  output ctan_rot_t         cell_o
);

  logic                      valid_q;
  ctan_rot_t                 data_q;
  ctan_rot_t                 data_d;
  logic signed [XY_W-1:0]    xs;
  logic signed [XY_W-1:0]    ys;
  logic signed [ANGLE_W-1:0] atan;
  logic                      cw;

  always_comb begin
    xs     = cell_i.x >>> step_i;
    ys     = cell_i.y >>> step_i;
    atan   = ctan_atan(step_i);
    cw     = cell_i.target < cell_i.sum;
    data_d = cell_i;
    if (cw) begin
      data_d.x   = cell_i.x + ys;
      data_d.y   = cell_i.y - xs;
      data_d.sum = cell_i.sum - atan;
    end else begin
      data_d.x   = cell_i.x - ys;
      data_d.y   = cell_i.y + xs;
      data_d.sum = cell_i.sum + atan;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/ctan_div_cell.sv =====
// ctan_div_cell: one restoring-division step (one quotient bit), registered.
// Depends on ctan_pkg.

module ctan_div_cell
  import ctan_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      en_i,
  input  ctan_div_t cell_i,
  output ctan_div_t cell_o
);

  logic              valid_q;
  ctan_div_t         data_q;
  ctan_div_t         data_d;
  logic [MAG_W:0]    shifted;
  logic [MAG_W:0]    diff;
  logic              ge;

  always_comb begin
    shifted     = {cell_i.rem, cell_i.dq[DQ_W-1]};
    ge          = shifted >= {1'b0, cell_i.den};
    diff        = shifted - {1'b0, cell_i.den};
    data_d      = cell_i;
    data_d.rem  = ge ? diff[MAG_W-1:0] : shifted[MAG_W-1:0];
    data_d.dq   = {cell_i.dq[DQ_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= cell_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  always_comb begin
    cell_o       = data_q;
    cell_o.valid = valid_q;
  end

endmodule

// ===== rtl/core/ctan_out_stage.sv =====
// ctan_out_stage: saturation of the quotient, output register and skid slot.
// Depends on ctan_pkg.

module ctan_out_stage
  import ctan_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  ctan_div_t        div_i,
  output logic             en_o,
  output logic             m_axis_tvalid_o,
  input  logic             m_axis_tready_i,
  output logic [TAN_W-1:0] m_axis_tdata_o,   // [31:0] tangent
  output logic [0:0]       m_axis_tuser_o    // [0] overflow
);

  ctan_res_t res_d;
  ctan_res_t out_q;
  ctan_res_t skid_q;
  logic      out_valid_q;
  logic      skid_valid_q;
  logic      out_free;

  always_comb begin
    res_d.overflow = 1'b0;
    res_d.tangent  = div_i.dq[TAN_W-1:0];
    if (div_i.xzero) begin
      res_d.overflow = 1'b1;
      res_d.tangent  = div_i.yneg ? TAN_MIN : TAN_MAX;
    end else if (!div_i.neg) begin
      if (div_i.dq[DQ_W-1:TAN_W-1] != '0) begin
        res_d.overflow = 1'b1;
        res_d.tangent  = TAN_MAX;
      end
    end else begin
      if (div_i.dq > DQ_W'(TAN_MIN)) begin
        res_d.overflow = 1'b1;
        res_d.tangent  = TAN_MIN;
      end else begin
        res_d.tangent  = ~div_i.dq[TAN_W-1:0] + TAN_W'(1);
      end
    end
  end

  // Pipeline moves only while the skid slot is empty.
  assign en_o     = !skid_valid_q;
  assign out_free = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || (div_i.valid && en_o);
      skid_valid_q <= 1'b0;
    end else if (div_i.valid && en_o) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_valid_q ? skid_q : res_d;
    end else if (div_i.valid && en_o) begin
      skid_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q.tangent;
  assign m_axis_tuser_o  = out_q.overflow;

  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid slot holds a result while output register is empty");

  a_xzero_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_i.valid && div_i.xzero) |-> res_d.overflow)
    else $error("zero divisor without overflow flag");

  a_sign_kept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_i.valid && !res_d.overflow && div_i.neg && div_i.dq != '0)
      |-> res_d.tangent[TAN_W-1])
    else $error("negative quotient lost its sign");

  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && !out_free) |=> skid_valid_q)
    else $error("skid slot dropped a result while output stalled");

endmodule

// ===== rtl/core/cordic_tangent.sv =====
// cordic_tangent: top level of the pipelined CORDIC tangent unit.
// Depends on ctan_pkg, ctan_rot_cell, ctan_div_cell, ctan_out_stage.
//
//  channel  | dir | handshake                 | payload
//  ---------+-----+---------------------------+------------------------------------
//  s_axis   | in  | s_axis_tvalid/tready      | tdata[15:0] angle (1/256 degree)
//  m_axis   | out | m_axis_tvalid/tready      | tdata[31:0] tangent Q16.16,
//           |     |                           | tuser[0] overflow
//
//  One request per cycle sustained while the output is not stalled; the path is
//  15 CORDIC cells, one operand-prep register, 34 division cells (one quotient
//  bit each) and the output register.
//  Reset clears only valid bits; payload registers are left as they are.
//  A stalled output fills a one-entry skid slot, then the whole chain holds
//  and s_axis_tready_o drops until the slot drains.

module cordic_tangent
  import ctan_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [ANGLE_W-1:0] s_axis_tdata_i,   // [15:0] angle
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [TAN_W-1:0]   m_axis_tdata_o,   // [31:0] tangent
  output logic [0:0]         m_axis_tuser_o    // [0] overflow
);

  logic      en;
  ctan_rot_t rot_chain [ITERATIONS+1];
  ctan_div_t div_chain [DIV_STEPS+1];
  ctan_div_t prep_d;
  ctan_div_t prep_q;
  logic      prep_valid_q;
  ctan_rot_t rot_last;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;

  // Feed the first cell: start vector (65535, 0), angle sum zero.
  always_comb begin
    rot_chain[0].valid  = s_axis_tvalid_i;
    rot_chain[0].target = s_axis_tdata_i;
    rot_chain[0].x      = X_START;
    rot_chain[0].y      = '0;
    rot_chain[0].sum    = '0;
  end

  assign s_axis_tready_o = en;

  // Rotation chain: cell i shifts by i and uses atan(2^-i).
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_rot
    ctan_rot_cell u_rot (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .step_i (STEP_W'(g)),
      .cell_i (rot_chain[g]),
      .cell_o (rot_chain[g+1])
    );
  end

  assign rot_last = rot_chain[ITERATIONS];

  // Operand prep: magnitudes and signs for the unsigned divider.
  always_comb begin
    mag_x = rot_last.x[XY_W-1] ? MAG_W'(-rot_last.x) : MAG_W'(rot_last.x);
    mag_y = rot_last.y[XY_W-1] ? MAG_W'(-rot_last.y) : MAG_W'(rot_last.y);
    prep_d.valid = rot_last.valid;
    prep_d.rem   = '0;
    prep_d.dq    = {mag_y, {FRAC_W{1'b0}}};
    prep_d.den   = mag_x;
    prep_d.neg   = rot_last.x[XY_W-1] ^ rot_last.y[XY_W-1];
    prep_d.xzero = rot_last.x == '0;
    prep_d.yneg  = rot_last.y[XY_W-1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_valid_q <= 1'b0;
    end else if (en) begin
      prep_valid_q <= prep_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_q <= prep_d;
    end
  end

  always_comb begin
    div_chain[0]       = prep_q;
    div_chain[0].valid = prep_valid_q;
  end

  // Division chain: one quotient bit per cell, MSB first.
  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    ctan_div_cell u_div (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .cell_i (div_chain[g]),
      .cell_o (div_chain[g+1])
    );
  end

  // Saturate, register, and absorb one result under output stall.
  ctan_out_stage u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .div_i           (div_chain[DIV_STEPS]),
    .en_o            (en),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule

// ===== bench/tb_top.sv =====
// tb_top: self-checking bench for the cordic_tangent stream unit.
// Needs ctan_pkg and cordic_tangent; predicts each tangent with its own
// 15-step rotation model and checks the output stream in order.
`timescale 1ns / 100ps

module tb_top;
  import ctan_pkg::*;

  localparam int unsigned CLK_HALF     = 4;
  localparam int unsigned RST_CYCLES   = 7;
  localparam int unsigned RANDOM_REQS  = 1000;
  localparam int unsigned IDLE_PCT     = 34;
  localparam int unsigned QUIET_FROM   = 400;     // no idling on either side in this window
  localparam int unsigned QUIET_TO     = 700;
  localparam int unsigned HOLD_AT      = 500;     // sender waits for the pipe to drain here
  localparam int unsigned DRAIN_CYCLES = 80;      // longer than the pipeline latency
  localparam int unsigned CYCLE_LIMIT  = 100000;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [TAN_W-1:0] tangent;
    logic             overflow;
  } tan_result_t;

  // Arctangent of 2^-i in 1/256 degree units.
  localparam longint ATAN_STEP [15] = '{
    11520, 6801, 3593, 1824, 916, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  logic               clk_i;
  logic               rst_ni;
  logic               s_valid;
  logic               s_ready;
  logic [ANGLE_W-1:0] s_angle;
  logic               m_valid;
  logic               m_ready;
  logic [TAN_W-1:0]   m_tangent;
  logic [0:0]         m_overflow;

  logic [ANGLE_W-1:0] angle_queue[$];     // requests waiting to be driven
  tan_result_t        tangent_expect[$];  // predicted results, oldest first
  int unsigned        cycle_cnt;
  int unsigned        sent_cnt;
  int unsigned        err_cnt;
  logic               in_fire;

  cordic_tangent u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_angle),
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_tangent),
    .m_axis_tuser_o  (m_overflow)
  );

  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // Run the rotation steps; steer by comparing the target with the running angle.
  function automatic void rotate_vector(input logic signed [ANGLE_W-1:0] angle,
                                        output longint x, output longint y);
    longint target;
    longint angle_acc;
    longint xs;
    longint ys;
    target    = angle;
    x         = 65535;
    y         = 0;
    angle_acc = 0;
    for (int i = 0; i < ITERATIONS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (target < angle_acc) begin
        x         = x + ys;
        y         = y - xs;
        angle_acc = angle_acc - ATAN_STEP[i];
      end else begin
        x         = x - ys;
        y         = y + xs;
        angle_acc = angle_acc + ATAN_STEP[i];
      end
    end
  endfunction

  // Divide y by x into Q16.16, truncating toward zero and saturating.
  function automatic tan_result_t predict_tangent(input logic signed [ANGLE_W-1:0] angle);
    longint      x;
    longint      y;
    longint      q;
    tan_result_t r;
    rotate_vector(angle, x, y);
    r.overflow = 1'b0;
    if (x == 0) begin
      q          = (y >= 0) ? 64'sd2147483647 : -64'sd2147483648;
      r.overflow = 1'b1;
    end else begin
      q = (y * 65536) / x;
      if (q > 64'sd2147483647) begin
        q          = 64'sd2147483647;
        r.overflow = 1'b1;
      end else if (q < -64'sd2147483648) begin
        q          = -64'sd2147483648;
        r.overflow = 1'b1;
      end
    end
    r.tangent = q[31:0];
    return r;
  endfunction

  function automatic logic quiet_window();
    return (cycle_cnt >= QUIET_FROM) && (cycle_cnt < QUIET_TO);
  endfunction

  // Fill the request queue: directed corners, searched corners, then random angles.
  initial begin
    longint      x;
    longint      y;
    int          zero_div_found;
    int          saturate_found;
    int          pick;
    int          a;
    tan_result_t r;
    zero_div_found = 0;
    saturate_found = 0;

    angle_queue.push_back(16'sd0);
    angle_queue.push_back(16'sd1);
    angle_queue.push_back(-16'sd1);
    angle_queue.push_back(16'sd32767);         // field extremes, far past convergence
    angle_queue.push_back(-16'sd32768);
    angle_queue.push_back(16'sd11520);         // +-45 degrees
    angle_queue.push_back(-16'sd11520);
    angle_queue.push_back(16'sd3840);
    angle_queue.push_back(16'sd23040);         // +-90 degrees, x close to zero
    angle_queue.push_back(-16'sd23040);
    angle_queue.push_back(16'sd25570);         // edge of convergence
    angle_queue.push_back(-16'sd25570);
    angle_queue.push_back(16'sd25571);
    angle_queue.push_back(-16'sd25571);
    angle_queue.push_back(16'h5555);           // alternating bit patterns
    angle_queue.push_back(16'hAAAA);

    // Search the angle space for a zero divisor and for quotient saturation.
    for (int s = -32768; s < 32768; s++) begin
      rotate_vector(ANGLE_W'(s), x, y);
      if (x == 0 && zero_div_found < 3) begin
        angle_queue.push_back(ANGLE_W'(s));
        zero_div_found++;
      end else if (x != 0 && saturate_found < 4) begin
        r = predict_tangent(ANGLE_W'(s));
        if (r.overflow) begin
          angle_queue.push_back(ANGLE_W'(s));
          saturate_found++;
        end
      end
    end

    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        a = $urandom_range(0, 65535);
      end else if (pick < 85) begin
        a = $urandom_range(0, 51140) - 25570;
      end else begin
        a = $urandom_range(0, 600) - 300 + (($urandom_range(0, 1) == 1) ? 23040 : -23040);
      end
      angle_queue.push_back(ANGLE_W'(a));
    end
  end

  // Hold reset low, then release it on a falling edge.
  initial begin
    rst_ni = 1'b0;
    repeat (RST_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  initial begin
    s_valid = 1'b0;
    s_angle = '0;
    m_ready = 1'b0;
    in_fire = 1'b0;
    sent_cnt  = 0;
    err_cnt   = 0;
    cycle_cnt = 0;
  end

  // Driver: advance on the falling edge once the current request was taken.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_valid || in_fire) begin
        if (angle_queue.size() == 0) begin
          s_valid <= 1'b0;
        end else if (sent_cnt == HOLD_AT && tangent_expect.size() != 0) begin
          s_valid <= 1'b0;   // hold until every outstanding result is back
        end else if (!quiet_window() && $urandom_range(0, 99) < IDLE_PCT) begin
          s_valid <= 1'b0;
        end else begin
          s_valid  <= 1'b1;
          s_angle  <= angle_queue.pop_front();
          sent_cnt <= sent_cnt + 1;
        end
      end
      m_ready <= quiet_window() || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Monitor: record accepted requests and check accepted results on the rising edge.
  always @(posedge clk_i) begin
    tan_result_t want;
    in_fire = rst_ni && s_valid && s_ready;
    if (in_fire) begin
      tangent_expect.push_back(predict_tangent(s_angle));
    end
    if (rst_ni && m_valid && m_ready) begin
      if (tangent_expect.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_REPORTS) begin
          $display("unexpected result: tangent=%h overflow=%b", m_tangent, m_overflow);
        end
      end else begin
        want = tangent_expect.pop_front();
        if (m_tangent !== want.tangent || m_overflow[0] !== want.overflow) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("mismatch at cycle %0d: tangent exp %h got %h, overflow exp %b got %b",
                     cycle_cnt, want.tangent, m_tangent, want.overflow, m_overflow);
          end
        end
      end
    end
  end

  // Watchdog: end the run with an error once the cycle limit is reached.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[cordic_tangent] ERROR");
      $finish;
    end
  end

  // End of test: wait for every request to go out and every result to come back.
  initial begin
    @(posedge rst_ni);
    @(posedge clk_i);
    while (angle_queue.size() != 0 || s_valid || tangent_expect.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (err_cnt == 0 && tangent_expect.size() == 0) begin
      $display("[cordic_tangent] OK");
    end else begin
      $display("[cordic_tangent] ERROR");
    end
    $finish;
  end

endmodule

// ===== cordic_tangent.f =====
rtl/core/ctan_pkg.sv
rtl/core/ctan_rot_cell.sv
rtl/core/ctan_div_cell.sv
rtl/core/ctan_out_stage.sv
rtl/core/cordic_tangent.sv
bench/tb_top.sv
